// ===== src/hbh_pkg.sv =====
`default_nettype none
package hbh_pkg;
  localparam int Q2_BINS_DEF     = 4;
  localparam int XB_BINS_DEF     = 4;
  localparam int T_BINS_DEF      = 1;
  localparam int ANGLE_BINS_DEF  = 12;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int SUM_W           = 48;
  localparam int VAL_W           = 16;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam logic [31:0] PHASE_PER_UNIT = 32'd83443;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_READ4 = 2'd1,
    OP_READA = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_Q2_LOWER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q2_TOP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XB_LOWER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XB_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T_EDGES  = 3'd4;
endpackage
`default_nettype wire

// ===== src/hbh_if.sv =====
`default_nettype none
interface hbh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] q2_value;
  logic [15:0] xb_value;
  logic [15:0] t_value;
  logic signed [15:0] phi_angle;
  logic signed [1:0]  helicity;
  logic [7:0]  read_index;
  modport source (output valid, operation, q2_value, xb_value, t_value, phi_angle,
                  helicity, read_index, input ready);
  modport sink (input valid, operation, q2_value, xb_value, t_value, phi_angle,
                helicity, read_index, output ready);
endinterface

interface hbh_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [7:0]  bin_number;
  logic [31:0] plus_count;
  logic [31:0] minus_count;
  logic [47:0] q2_sum;
  logic [47:0] xb_sum;
  logic [47:0] t_sum;
  modport source (output valid, accepted, bin_number, plus_count, minus_count, q2_sum,
                  xb_sum, t_sum, input ready);
  modport sink (input valid, accepted, bin_number, plus_count, minus_count, q2_sum,
                xb_sum, t_sum, output ready);
endinterface
`default_nettype wire

// ===== src/hbh_binner.sv =====
`default_nettype none
// Registered bin lookup: edges compare, angle phase multiply, flat index.
module hbh_binner #(
  parameter int Q2_BINS    = 4,
  parameter int XB_BINS    = 4,
  parameter int ANGLE_BINS = 12,
  parameter int IDX_W      = 8,
  parameter int ANG_W      = 4
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] q2_lower,
  input  wire logic [15:0] q2_top,
  input  wire logic [63:0] xb_lower,
  input  wire logic [15:0] xb_top,
  input  wire logic [31:0] t_edges,
  input  wire logic [15:0] q2_value,
  input  wire logic [15:0] xb_value,
  input  wire logic [15:0] t_value,
  input  wire logic [15:0] phi_angle,
  output logic             in_range_r,
  output logic [IDX_W-1:0] bin_r,
  output logic [ANG_W-1:0] ang_r
);
  import hbh_pkg::*;

  logic [1:0] iq, ix;
  logic       fq, fx, ft;
  logic [31:0] phase;
  logic [37:0] scaled;
  logic [IDX_W-1:0] bin_nxt;

  function automatic logic [16:0] edge_of(input logic [63:0] lo, input logic [15:0] top,
                                          input int k, input int n);
    if (k >= n) edge_of = {1'b0, top};
    else        edge_of = {1'b0, lo[16*k +: 16]};
  endfunction

  // Pick first matching bin on each axis
  always_comb begin
    fq = 1'b0; iq = '0;
    fx = 1'b0; ix = '0;
    for (int k = Q2_BINS - 1; k >= 0; k--) begin
      if ({1'b0, q2_value} >= edge_of(q2_lower, q2_top, k, Q2_BINS) &&
          {1'b0, q2_value} <  edge_of(q2_lower, q2_top, k + 1, Q2_BINS)) begin
        fq = 1'b1; iq = 2'(k);
      end
    end
    for (int k = XB_BINS - 1; k >= 0; k--) begin
      if ({1'b0, xb_value} >= edge_of(xb_lower, xb_top, k, XB_BINS) &&
          {1'b0, xb_value} <  edge_of(xb_lower, xb_top, k + 1, XB_BINS)) begin
        fx = 1'b1; ix = 2'(k);
      end
    end
    ft = (t_value >= t_edges[15:0]) && (t_value < t_edges[31:16]);
    phase  = 32'({{16{phi_angle[15]}}, phi_angle} * PHASE_PER_UNIT);
    scaled = 38'((38'(phase) * 38'(ANGLE_BINS)) >> 32);
    bin_nxt = IDX_W'((int'(iq) * XB_BINS + int'(ix)) * ANGLE_BINS + int'(scaled));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_range_r <= fq && fx && ft;
      bin_r      <= bin_nxt;
      ang_r      <= ANG_W'(scaled);
    end
  end
endmodule
`default_nettype wire

// ===== src/hbh_store.sv =====
`default_nettype none
// Bin store: synchronous memories with read-modify-write and valid bits for clear.
module hbh_store #(
  parameter int TOTAL       = 192,
  parameter int ANGLE_BINS  = 12,
  parameter int COUNT_WIDTH = 32,
  parameter int IDX_W       = 8,
  parameter int ANG_W       = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_bin,
  input  wire logic [ANG_W-1:0] rd_ang,
  output logic [COUNT_WIDTH-1:0] rp_r, rm_r, ap_r, am_r,
  output logic [47:0]           rq_r, rx_r, rt_r,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_bin,
  input  wire logic [ANG_W-1:0] wr_ang,
  input  wire logic [COUNT_WIDTH-1:0] wp, wm, wap, wam,
  input  wire logic [47:0]      wq, wx, wt
);
  import hbh_pkg::*;

  logic [COUNT_WIDTH-1:0] pm [TOTAL];
  logic [COUNT_WIDTH-1:0] mm [TOTAL];
  logic [47:0] qm [TOTAL];
  logic [47:0] xm [TOTAL];
  logic [47:0] tm [TOTAL];
  logic [COUNT_WIDTH-1:0] apm [ANGLE_BINS];
  logic [COUNT_WIDTH-1:0] amm [ANGLE_BINS];
  logic [TOTAL-1:0]      vb_r;
  logic [ANGLE_BINS-1:0] va_r;
  logic vb_rd_r, va_rd_r;
  logic [COUNT_WIDTH-1:0] p_q, m_q, ap_q, am_q;
  logic [47:0] q_q, x_q, t_q;

  // Clear valid bits on reset, set them on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
      va_r <= '0;
    end else if (wr_en) begin
      vb_r[wr_bin] <= 1'b1;
      va_r[wr_ang] <= 1'b1;
    end
  end

  // Memory write; both angle words are written back together
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pm[wr_bin] <= wp; mm[wr_bin] <= wm;
      qm[wr_bin] <= wq; xm[wr_bin] <= wx; tm[wr_bin] <= wt;
      apm[wr_ang] <= wap;
      amm[wr_ang] <= wam;
    end
  end

  // Memory read, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      p_q <= pm[rd_bin]; m_q <= mm[rd_bin];
      q_q <= qm[rd_bin]; x_q <= xm[rd_bin]; t_q <= tm[rd_bin];
      ap_q <= apm[rd_ang]; am_q <= amm[rd_ang];
      vb_rd_r <= vb_r[rd_bin];
      va_rd_r <= va_r[rd_ang];
    end
  end

  // Mask entries never written; every write stores all words of its entry
  always_comb begin
    rp_r = vb_rd_r ? p_q : '0;
    rm_r = vb_rd_r ? m_q : '0;
    rq_r = vb_rd_r ? q_q : '0;
    rx_r = vb_rd_r ? x_q : '0;
    rt_r = vb_rd_r ? t_q : '0;
    ap_r = va_rd_r ? ap_q : '0;
    am_r = va_rd_r ? am_q : '0;
  end
endmodule
`default_nettype wire

// ===== src/helicity_binned_histogram.sv =====
`default_nettype none
// Channel | dir | handshake    | payload
// in      | in  | valid/ready  | operation, values, angle, helicity, read_index
// out     | out | valid/ready  | accepted, bin_number, counts, sums
// cfg     | in  | we only      | index (3), data (64)
// Each item passes through bin lookup register, memory read, then update and write-back.
// Items run one at a time through the read-modify-write of the bin memory.
// Reset clears valid bits of every entry at once; no clearing pass.
// A waiting result holds in the output register; the next item waits until it is taken.
module helicity_binned_histogram #(
  parameter int Q2_BINS     = hbh_pkg::Q2_BINS_DEF,
  parameter int XB_BINS     = hbh_pkg::XB_BINS_DEF,
  parameter int T_BINS      = hbh_pkg::T_BINS_DEF,
  parameter int ANGLE_BINS  = hbh_pkg::ANGLE_BINS_DEF,
  parameter int COUNT_WIDTH = hbh_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hbh_in_if.sink    in_ch,
  hbh_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [hbh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hbh_pkg::CFG_W-1:0]     cfg_data
);
  import hbh_pkg::*;

  localparam int TOTAL = Q2_BINS * XB_BINS * T_BINS * ANGLE_BINS;
  localparam int IDX_W = 8;
  localparam int ANG_W = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [48:0] SMAX = {1'b0, {48{1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_READ = 3'b010, S_UPD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [63:0] q2_lower_r, xb_lower_r;
  logic [15:0] q2_top_r, xb_top_r;
  logic [31:0] t_edges_r;

  logic [1:0]  op_r;
  logic [1:0]  hel_r;
  logic [15:0] q2_r, xb_r, t_r;
  logic [7:0]  idx_r;

  logic             in_range;
  logic [IDX_W-1:0] bin;
  logic [ANG_W-1:0] ang;
  logic             take;
  logic             upd_ok;
  logic             hel_ok;
  logic [IDX_W-1:0] rd_bin;
  logic [ANG_W-1:0] rd_ang;
  logic [COUNT_WIDTH-1:0] rp, rm, ap, am, np, nm, nap, nam;
  logic [47:0] rq, rx, rt, nq, nx, nt;
  logic [48:0] sq, sx, st;
  logic out_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_lower_r <= '0; q2_top_r <= 16'hFFFF;
      xb_lower_r <= '0; xb_top_r <= 16'hFFFF;
      t_edges_r  <= 32'hFFFF0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_Q2_LOWER: q2_lower_r <= cfg_data;
        REG_Q2_TOP:   q2_top_r   <= cfg_data[15:0];
        REG_XB_LOWER: xb_lower_r <= cfg_data;
        REG_XB_TOP:   xb_top_r   <= cfg_data[15:0];
        REG_T_EDGES:  t_edges_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign take = in_ch.valid && in_ch.ready;

  // Capture item
  always_ff @(posedge clk) begin
    if (take) begin
      op_r  <= in_ch.operation;
      hel_r <= in_ch.helicity;
      q2_r  <= in_ch.q2_value;
      xb_r  <= in_ch.xb_value;
      t_r   <= in_ch.t_value;
      idx_r <= in_ch.read_index;
    end
  end

  hbh_binner #(.Q2_BINS(Q2_BINS), .XB_BINS(XB_BINS), .ANGLE_BINS(ANGLE_BINS),
               .IDX_W(IDX_W), .ANG_W(ANG_W)) u_bin (
    .clk(clk), .en(take),
    .q2_lower(q2_lower_r), .q2_top(q2_top_r), .xb_lower(xb_lower_r), .xb_top(xb_top_r),
    .t_edges(t_edges_r), .q2_value(in_ch.q2_value), .xb_value(in_ch.xb_value),
    .t_value(in_ch.t_value), .phi_angle(in_ch.phi_angle),
    .in_range_r(in_range), .bin_r(bin), .ang_r(ang)
  );

  // Read address: event bin or read index
  always_comb begin
    rd_bin = (op_r == OP_EVENT) ? bin : idx_r;
    rd_ang = (op_r == OP_EVENT) ? ang : ANG_W'(idx_r);
  end

  assign hel_ok = (hel_r == 2'b01) || (hel_r == 2'b11);
  assign upd_ok = (op_r == OP_EVENT) && in_range && hel_ok;

  hbh_store #(.TOTAL(TOTAL), .ANGLE_BINS(ANGLE_BINS), .COUNT_WIDTH(COUNT_WIDTH),
              .IDX_W(IDX_W), .ANG_W(ANG_W)) u_store (
    .clk(clk), .rst_n(rst_n), .rd_en(state_r == S_READ), .rd_bin(rd_bin), .rd_ang(rd_ang),
    .rp_r(rp), .rm_r(rm), .ap_r(ap), .am_r(am), .rq_r(rq), .rx_r(rx), .rt_r(rt),
    .wr_en((state_r == S_UPD) && upd_ok),
    .wr_bin(bin), .wr_ang(ang), .wp(np), .wm(nm), .wap(nap), .wam(nam),
    .wq(nq), .wx(nx), .wt(nt)
  );

  // Saturating update
  always_comb begin
    np  = rp; nm = rm; nap = ap; nam = am;
    if (hel_r == 2'b01) begin
      np  = (rp == CMAX) ? rp : rp + 1'b1;
      nap = (ap == CMAX) ? ap : ap + 1'b1;
    end else begin
      nm  = (rm == CMAX) ? rm : rm + 1'b1;
      nam = (am == CMAX) ? am : am + 1'b1;
    end
    sq = {1'b0, rq} + 49'(q2_r);
    sx = {1'b0, rx} + 49'(xb_r);
    st = {1'b0, rt} + 49'(t_r);
    nq = (sq > SMAX) ? 48'(SMAX) : sq[47:0];
    nx = (sx > SMAX) ? 48'(SMAX) : sx[47:0];
    nt = (st > SMAX) ? 48'(SMAX) : st[47:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (take) state_nxt = S_READ;
      S_READ: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_UPD) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      out_ch.accepted    <= 1'b0;
      out_ch.bin_number  <= '0;
      out_ch.plus_count  <= '0;
      out_ch.minus_count <= '0;
      out_ch.q2_sum      <= '0;
      out_ch.xb_sum      <= '0;
      out_ch.t_sum       <= '0;
      case (op_r)
        OP_EVENT: if (upd_ok) begin
          out_ch.accepted    <= 1'b1;
          out_ch.bin_number  <= bin;
          out_ch.plus_count  <= 32'(np);
          out_ch.minus_count <= 32'(nm);
          out_ch.q2_sum <= nq; out_ch.xb_sum <= nx; out_ch.t_sum <= nt;
        end
        OP_READ4: begin
          out_ch.bin_number <= idx_r;
          if (32'(idx_r) < 32'(TOTAL)) begin
            out_ch.accepted    <= 1'b1;
            out_ch.plus_count  <= 32'(rp);
            out_ch.minus_count <= 32'(rm);
            out_ch.q2_sum <= rq; out_ch.xb_sum <= rx; out_ch.t_sum <= rt;
          end
        end
        OP_READA: begin
          out_ch.bin_number <= idx_r;
          if (32'(idx_r) < 32'(ANGLE_BINS)) begin
            out_ch.accepted    <= 1'b1;
            out_ch.plus_count  <= 32'(ap);
            out_ch.minus_count <= 32'(am);
          end
        end
        default: ;
      endcase
    end
  end
  assign out_ch.valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_UPD)) else $error("read not followed by update");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
`endif
endmodule
`default_nettype wire

// ===== tb/helicity_binned_histogram_tb.sv =====
`default_nettype none
module helicity_binned_histogram_tb;
  import hbh_pkg::*;

  localparam int NQ2 = Q2_BINS_DEF;
  localparam int NXB = XB_BINS_DEF;
  localparam int NT = T_BINS_DEF;
  localparam int NANG = ANGLE_BINS_DEF;
  localparam int NBINS = NQ2 * NXB * NT * NANG;
  localparam logic [31:0] COUNT_SAT = 32'hFFFF_FFFF;
  localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    op_t         operation;
    logic [15:0] q2_value;
    logic [15:0] xb_value;
    logic [15:0] t_value;
    logic [15:0] phi_angle;
    logic [1:0]  helicity;
    logic [7:0]  read_index;
  } event_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  bin_number;
    logic [31:0] plus_count;
    logic [31:0] minus_count;
    logic [47:0] q2_sum;
    logic [47:0] xb_sum;
    logic [47:0] t_sum;
  } bin_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  hbh_in_if in_ch();
  hbh_out_if out_ch();

  helicity_binned_histogram DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow histogram and edge registers
  logic [63:0] q2_lower_sh, xb_lower_sh;
  logic [15:0] q2_top_sh, xb_top_sh;
  logic [31:0] t_edges_sh;
  logic [31:0] plus_sh [NBINS];
  logic [31:0] minus_sh [NBINS];
  logic [47:0] q2_sum_sh [NBINS];
  logic [47:0] xb_sum_sh [NBINS];
  logic [47:0] t_sum_sh [NBINS];
  logic [31:0] ang_plus_sh [NANG];
  logic [31:0] ang_minus_sh [NANG];

  event_item_t pending_items[$];
  bin_report_t expected_reports[$];
  int mismatches = 0;
  int cycles = 0;
  int gap_left = 0;
  int burst_left = 0;

  function automatic int axis_bin(logic [15:0] v, logic [63:0] lower, logic [15:0] top,
                                  int nb);
    logic [15:0] lo, hi;
    for (int k = 0; k < nb; k++) begin
      lo = lower[16*k +: 16];
      hi = (k + 1 >= nb) ? top : lower[16*(k+1) +: 16];
      if (v >= lo && v < hi) return k;
    end
    return -1;
  endfunction

  function automatic int phi_bin(logic [15:0] raw);
    logic [31:0] phase;
    logic [35:0] scaled;
    phase = 32'($signed(raw) * $signed({1'b0, PHASE_PER_UNIT}));
    scaled = 36'({4'd0, phase} * NANG) ;
    return int'(scaled[35:32]);
  endfunction

  function automatic logic [31:0] count_inc(logic [31:0] c);
    return (c == COUNT_SAT) ? c : c + 32'd1;
  endfunction

  function automatic logic [47:0] sum_inc(logic [47:0] s, logic [15:0] v);
    logic [48:0] r;
    r = {1'b0, s} + 49'(v);
    return r[48] ? SUM_SAT : r[47:0];
  endfunction

  // append one item to the pending queue
  function automatic void add_item(event_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // apply one item to the shadow histogram and return its report
  function automatic bin_report_t histogram_update(event_item_t it);
    bin_report_t r;
    int iq, ix, itb, ip, b;
    r = '0;
    case (it.operation)
      OP_EVENT: begin
        iq = axis_bin(it.q2_value, q2_lower_sh, q2_top_sh, NQ2);
        ix = axis_bin(it.xb_value, xb_lower_sh, xb_top_sh, NXB);
        itb = axis_bin(it.t_value, {48'd0, t_edges_sh[15:0]}, t_edges_sh[31:16], NT);
        ip = phi_bin(it.phi_angle);
        if (iq >= 0 && ix >= 0 && itb >= 0 && (it.helicity == 2'b01 || it.helicity == 2'b11))
        begin
          b = ((iq * NXB + ix) * NT + itb) * NANG + ip;
          if (it.helicity == 2'b01) begin
            plus_sh[b] = count_inc(plus_sh[b]);
            ang_plus_sh[ip] = count_inc(ang_plus_sh[ip]);
          end else begin
            minus_sh[b] = count_inc(minus_sh[b]);
            ang_minus_sh[ip] = count_inc(ang_minus_sh[ip]);
          end
          q2_sum_sh[b] = sum_inc(q2_sum_sh[b], it.q2_value);
          xb_sum_sh[b] = sum_inc(xb_sum_sh[b], it.xb_value);
          t_sum_sh[b] = sum_inc(t_sum_sh[b], it.t_value);
          r = '{1'b1, 8'(b), plus_sh[b], minus_sh[b], q2_sum_sh[b], xb_sum_sh[b],
                t_sum_sh[b]};
        end
      end
      OP_READ4: begin
        r.bin_number = it.read_index;
        if (it.read_index < NBINS) begin
          b = int'(it.read_index);
          r = '{1'b1, it.read_index, plus_sh[b], minus_sh[b], q2_sum_sh[b],
                xb_sum_sh[b], t_sum_sh[b]};
        end
      end
      OP_READA: begin
        r.bin_number = it.read_index;
        if (it.read_index < NANG) begin
          r.accepted = 1'b1;
          r.plus_count = ang_plus_sh[it.read_index];
          r.minus_count = ang_minus_sh[it.read_index];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // feed items in bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_reports.insert(expected_reports.size(),
                                histogram_update(pending_items.pop_front()));
      if ((in_ch.valid && !in_ch.ready) || pending_items.size() == 0) begin
        if (!in_ch.valid || in_ch.ready) in_ch.valid <= 1'b0;
      end else if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          {in_ch.operation, in_ch.q2_value, in_ch.xb_value, in_ch.t_value,
           in_ch.phi_angle, in_ch.helicity, in_ch.read_index} <= pending_items[0];
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // stall the result side on its own pattern, check each item taken
  always @(posedge clk) begin
    bin_report_t got, want;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ((cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.accepted, out_ch.bin_number, out_ch.plus_count, out_ch.minus_count,
                out_ch.q2_sum, out_ch.xb_sum, out_ch.t_sum};
        if (expected_reports.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected item: %h", got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch: expected %h actual %h", want, got);
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("helicity_binned_histogram_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_Q2_LOWER: q2_lower_sh = val;
      REG_Q2_TOP:   q2_top_sh = val[15:0];
      REG_XB_LOWER: xb_lower_sh = val;
      REG_XB_TOP:   xb_top_sh = val[15:0];
      REG_T_EDGES:  t_edges_sh = val[31:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic event_item_t random_event(bit in_range);
    event_item_t it;
    it.operation = OP_EVENT;
    it.q2_value = 16'($urandom);
    it.xb_value = 16'($urandom);
    it.t_value = 16'($urandom);
    it.phi_angle = (in_range || $urandom_range(0, 1)) ? 16'($signed($urandom_range(0, 51472))
                   - 25736) : 16'($urandom);
    it.helicity = ($urandom_range(0, 5) == 0) ? 2'($urandom) :
                  ($urandom_range(0, 1) ? 2'b01 : 2'b11);
    it.read_index = 8'($urandom);
    return it;
  endfunction

  function automatic event_item_t random_read();
    event_item_t it;
    it = random_event(1'b1);
    it.operation = ($urandom_range(0, 9) == 0) ? OP_NONE :
                   ($urandom_range(0, 1) ? OP_READ4 : OP_READA);
    it.read_index = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                    (it.operation == OP_READA ? 8'($urandom_range(0, NANG - 1)) :
                     8'($urandom_range(0, NBINS - 1)));
    return it;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      add_item($urandom_range(0, 3) == 0 ? random_read() : random_event(1'b1));
    drain();
  endtask

  initial begin
    event_item_t it;
    in_ch.valid = 1'b0;
    {in_ch.operation, in_ch.q2_value, in_ch.xb_value, in_ch.t_value, in_ch.phi_angle,
     in_ch.helicity, in_ch.read_index} = '0;
    out_ch.ready = 1'b0;
    q2_lower_sh = '0; q2_top_sh = 16'hFFFF;
    xb_lower_sh = '0; xb_top_sh = 16'hFFFF;
    t_edges_sh = 32'hFFFF_0000;
    for (int b = 0; b < NBINS; b++) begin
      plus_sh[b] = '0; minus_sh[b] = '0;
      q2_sum_sh[b] = '0; xb_sum_sh[b] = '0; t_sum_sh[b] = '0;
    end
    for (int a = 0; a < NANG; a++) begin
      ang_plus_sh[a] = '0; ang_minus_sh[a] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset edges put everything below 0xFFFF in the last bin of each axis
    it = '0;
    it.helicity = 2'b01;
    add_item(it);
    it.phi_angle = 16'sd25736; add_item(it);
    it.phi_angle = -16'sd25736; it.helicity = 2'b11; add_item(it);
    it.phi_angle = 16'h7FFF; add_item(it);
    it.phi_angle = 16'h8000; add_item(it);
    it.q2_value = 16'hFFFE; it.xb_value = 16'hFFFE; it.t_value = 16'hFFFE;
    add_item(it);
    it.q2_value = 16'hFFFF; add_item(it);
    it.q2_value = '0; it.t_value = 16'hFFFF; add_item(it);
    it.t_value = '0; it.helicity = 2'b00; add_item(it);
    it.helicity = 2'b10; add_item(it);
    it.operation = OP_READ4; it.read_index = '0; add_item(it);
    it.read_index = 8'(NBINS - 1); add_item(it);
    it.read_index = 8'(NBINS); add_item(it);
    it.read_index = 8'hFF; add_item(it);
    it.operation = OP_READA; it.read_index = 8'(NANG - 1); add_item(it);
    it.read_index = 8'(NANG); add_item(it);
    it.read_index = '0; add_item(it);
    it.operation = OP_NONE; it.read_index = 8'hAA; add_item(it);
    drain();

    // four-bin edges on both axes, narrow t window
    write_reg(REG_Q2_LOWER, 64'hC000_8000_4000_1000);
    write_reg(REG_Q2_TOP, 64'h0000_0000_0000_F000);
    write_reg(REG_XB_LOWER, 64'h9000_6000_3000_0800);
    write_reg(REG_XB_TOP, 64'hFFFF_FFFF_FFFF_E000);
    write_reg(REG_T_EDGES, 64'hFFFF_FFFF_C000_2000);
    random_phase(250);

    // extremes: full range, empty and overlapping edges, random edges
    write_reg(REG_Q2_LOWER, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(REG_Q2_TOP, 64'hFFFF);
    write_reg(REG_XB_LOWER, 64'h0000_0000_0000_0000);
    write_reg(REG_XB_TOP, 64'h0);
    write_reg(REG_T_EDGES, 64'h0);
    random_phase(60);
    write_reg(REG_XB_LOWER, 64'h0003_0002_0001_0000);
    write_reg(REG_XB_TOP, 64'hFFFF);
    write_reg(REG_T_EDGES, 64'hFFFF_0000);
    random_phase(150);
    write_reg(REG_Q2_LOWER, {$urandom, $urandom});
    write_reg(REG_Q2_TOP, 64'($urandom));
    write_reg(REG_XB_LOWER, {$urandom, $urandom});
    write_reg(REG_XB_TOP, 64'($urandom));
    write_reg(REG_T_EDGES, {32'hFFFF_FFFF, $urandom});
    random_phase(170);

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("helicity_binned_histogram_tb OK");
    end else begin
      $display("helicity_binned_histogram_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== helicity_binned_histogram.f =====
src/hbh_pkg.sv
src/hbh_if.sv
src/hbh_binner.sv
src/hbh_store.sv
src/helicity_binned_histogram.sv
tb/helicity_binned_histogram_tb.sv
